@@ hw/rtl/pclk_pkg.sv @@
// ----------------------------------------------------------------------------
// pclk_pkg: shared types and constants for the PIN code lock controller
// Event codes, key codes, notice codes, register indexes, reset values and the
// control structs passed between the lock datapath modules.
// ----------------------------------------------------------------------------
package pclk_pkg;

   // default number of code digits
   localparam int CODE_LENGTH_DEFAULT = 4;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // event kinds
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_KEY    = 2'd1;
   localparam logic [1:0] CMD_CARD   = 2'd2;
   localparam logic [1:0] CMD_BUTTON = 2'd3;

   // key codes
   localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
   localparam logic [3:0] KEY_CLEAR     = 4'd10;
   localparam logic [3:0] KEY_ENTER     = 4'd12;

   // notice codes
   localparam logic [1:0] NOTE_NONE  = 2'd0;
   localparam logic [1:0] NOTE_OK    = 2'd1;
   localparam logic [1:0] NOTE_WRONG = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCESS_CODE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_DURATION   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTICE_DURATION = 2'd2;

   // register reset values
   localparam logic [15:0] ACCESS_CODE_RESET     = 16'h1346;
   localparam logic [15:0] OPEN_DURATION_RESET   = 16'd3000;
   localparam logic [15:0] NOTICE_DURATION_RESET = 16'd1500;

   // control for the digit entry store
   typedef struct packed {
      logic       push;    // digit key seen
      logic       clear;   // clear or enter key seen
      logic [3:0] digit;
   } entry_ctrl_type;

   // control for the open and notice timers
   typedef struct packed {
      logic tick;
      logic wipe;          // display line erased
      logic check;         // enter key evaluated
      logic match;         // entry equals the code
      logic grant;         // card or button
   } timer_ctrl_type;

endpackage

@@ hw/rtl/pclk_entry.sv @@
// ----------------------------------------------------------------------------
// pclk_entry: digit entry store and code compare
// Holds up to CODE_LENGTH digits and compares a full entry with the code.
// ----------------------------------------------------------------------------
module pclk_entry #(
   parameter int CODE_LENGTH = pclk_pkg::CODE_LENGTH_DEFAULT,
   parameter int CNT_W       = $clog2(CODE_LENGTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  pclk_pkg::entry_ctrl_type ctrl,
   input  logic [15:0]            access_code,
   output logic                   has_room,
   output logic                   match,
   output logic [CNT_W-1:0]       count_in
);

   localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

   logic [3:0]       entry_digits_ff [CODE_LENGTH];
   logic [CNT_W-1:0] entry_count_ff;
   logic [CODE_LENGTH-1:0] digit_eq;
   logic             take;

   assign has_room = (entry_count_ff < CNT_W'(CODE_LENGTH));
   assign take     = step && ctrl.push && has_room;

   // first digit sits in the highest code nibble; nibbles beyond bit 15 read as zero
   for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_cmp
      localparam int POS = CODE_LENGTH - 1 - i;
      if (POS < 4) begin : g_in
         assign digit_eq[i] = (entry_digits_ff[i] == access_code[POS*4 +: 4]);
      end else begin : g_out
         assign digit_eq[i] = (entry_digits_ff[i] == 4'd0);
      end
   end

   assign match = (entry_count_ff == CNT_W'(CODE_LENGTH)) && (&digit_eq);

   always_comb begin
      count_in = entry_count_ff;
      if (step && ctrl.clear) begin
         count_in = '0;
      end else if (take) begin
         count_in = entry_count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         entry_digits_ff[entry_count_ff[IDX_W-1:0]] <= ctrl.digit;
      end
   end

endmodule

@@ hw/rtl/pclk_timers.sv @@
// ----------------------------------------------------------------------------
// pclk_timers: open timer and notice timer
// Loads, counts down and erases the lock opening and the shown notice.
// ----------------------------------------------------------------------------
module pclk_timers (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  pclk_pkg::timer_ctrl_type ctrl,
   input  logic [15:0]              open_duration,
   input  logic [15:0]              notice_duration,
   output logic                     lock_open_in,
   output logic [1:0]               notice_in
);

   logic [15:0] open_remaining_ff,   open_remaining_in;
   logic [15:0] notice_remaining_ff, notice_remaining_in;
   logic [1:0]  notice_kind_ff,      notice_kind_in;

   always_comb begin
      open_remaining_in   = open_remaining_ff;
      notice_remaining_in = notice_remaining_ff;
      notice_kind_in      = notice_kind_ff;
      if (step) begin
         if (ctrl.tick) begin
            if (open_remaining_ff != 16'd0) begin
               open_remaining_in = open_remaining_ff - 16'd1;
            end
            if (notice_remaining_ff != 16'd0) begin
               notice_remaining_in = notice_remaining_ff - 16'd1;
               if (notice_remaining_ff == 16'd1) begin
                  notice_kind_in = pclk_pkg::NOTE_NONE;
               end
            end
         end else if (ctrl.wipe) begin
            notice_remaining_in = 16'd0;
            notice_kind_in      = pclk_pkg::NOTE_NONE;
         end else if (ctrl.check) begin
            notice_remaining_in = notice_duration;
            // zero duration: the notice is already expired
            if (notice_duration == 16'd0) begin
               notice_kind_in = pclk_pkg::NOTE_NONE;
            end else if (ctrl.match) begin
               notice_kind_in = pclk_pkg::NOTE_OK;
            end else begin
               notice_kind_in = pclk_pkg::NOTE_WRONG;
            end
            if (ctrl.match) begin
               open_remaining_in = open_duration;
            end
         end else if (ctrl.grant) begin
            open_remaining_in = open_duration;
         end
      end
   end

   assign lock_open_in = (open_remaining_in != 16'd0);
   assign notice_in    = notice_kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_remaining_ff   <= 16'd0;
         notice_remaining_ff <= 16'd0;
         notice_kind_ff      <= pclk_pkg::NOTE_NONE;
      end else begin
         open_remaining_ff   <= open_remaining_in;
         notice_remaining_ff <= notice_remaining_in;
         notice_kind_ff      <= notice_kind_in;
      end
   end

endmodule

@@ hw/rtl/pin_code_lock_controller.sv @@
// Path: a req transfer lands in the input register; its result moves into the
//   rsp register once the result register can advance, raising rsp_valid.
// Throughput: one event per cycle unless stalled; rsp frees while being read.
// Reset (synchronous): entry empty, lock closed, no notice, code 0x1346,
//   open 3000 ticks, notice 1500 ticks. Digit store is not reset.
// ----------------------------------------------------------------------------
// pin_code_lock_controller: keypad code lock with timed opening and notices
// Input register, event decode, entry store and timers, result register.
// ----------------------------------------------------------------------------
module pin_code_lock_controller #(
   parameter int CODE_LENGTH = pclk_pkg::CODE_LENGTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [pclk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pclk_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_command,
   input  logic [3:0]                       req_key_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_lock_open,
   output logic [2:0]                       rsp_digits_entered,
   output logic [1:0]                       rsp_notice,
   output logic                             rsp_code_checked
);

   localparam int CNT_W = $clog2(CODE_LENGTH + 1);

   // configuration
   logic [15:0] access_code_ff, open_duration_ff, notice_duration_ff;

   // input register
   logic       in_valid_ff;
   logic [1:0] in_command_ff;
   logic [3:0] in_key_ff;

   // result register
   logic       out_valid_ff;
   logic       out_lock_open_ff;
   logic [2:0] out_digits_ff;
   logic [1:0] out_notice_ff;
   logic       out_checked_ff;

   logic advance, step, req_take;
   logic is_key, is_numeral, is_clear, is_enter;
   pclk_pkg::entry_ctrl_type entry_ctrl;
   pclk_pkg::timer_ctrl_type timer_ctrl;
   logic             has_room, match, lock_open_in;
   logic [CNT_W-1:0] count_in;
   logic [1:0]       notice_in;
   logic [CNT_W+2:0] count_wide;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         access_code_ff     <= pclk_pkg::ACCESS_CODE_RESET;
         open_duration_ff   <= pclk_pkg::OPEN_DURATION_RESET;
         notice_duration_ff <= pclk_pkg::NOTICE_DURATION_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pclk_pkg::CSR_ACCESS_CODE:     access_code_ff     <= csr_write_data;
            pclk_pkg::CSR_OPEN_DURATION:   open_duration_ff   <= csr_write_data;
            pclk_pkg::CSR_NOTICE_DURATION: notice_duration_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_command_ff <= req_command;
         in_key_ff     <= req_key_value;
      end
   end

   // event decode
   assign is_key     = (in_command_ff == pclk_pkg::CMD_KEY);
   assign is_numeral = is_key && (in_key_ff <= pclk_pkg::KEY_DIGIT_MAX);
   assign is_clear   = is_key && (in_key_ff == pclk_pkg::KEY_CLEAR);
   assign is_enter   = is_key && (in_key_ff == pclk_pkg::KEY_ENTER);

   assign entry_ctrl.push  = is_numeral;
   assign entry_ctrl.clear = is_clear || is_enter;
   assign entry_ctrl.digit = in_key_ff;

   assign timer_ctrl.tick  = (in_command_ff == pclk_pkg::CMD_TICK);
   assign timer_ctrl.wipe  = is_clear || (is_numeral && has_room);
   assign timer_ctrl.check = is_enter;
   assign timer_ctrl.match = match;
   assign timer_ctrl.grant = (in_command_ff == pclk_pkg::CMD_CARD) ||
                             (in_command_ff == pclk_pkg::CMD_BUTTON);

   pclk_entry #(
      .CODE_LENGTH (CODE_LENGTH),
      .CNT_W       (CNT_W)
   ) u_entry (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .ctrl        (entry_ctrl),
      .access_code (access_code_ff),
      .has_room    (has_room),
      .match       (match),
      .count_in    (count_in)
   );

   pclk_timers u_timers (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .ctrl            (timer_ctrl),
      .open_duration   (open_duration_ff),
      .notice_duration (notice_duration_ff),
      .lock_open_in    (lock_open_in),
      .notice_in       (notice_in)
   );

   assign count_wide = {3'd0, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_lock_open_ff <= lock_open_in;
         out_digits_ff    <= count_wide[2:0];
         out_notice_ff    <= notice_in;
         out_checked_ff   <= is_enter;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_lock_open      = out_lock_open_ff;
   assign rsp_digits_entered = out_digits_ff;
   assign rsp_notice         = out_notice_ff;
   assign rsp_code_checked   = out_checked_ff;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall with empty input register");

   a_item_moves_on: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("held item did not reach the result register");

   a_checked_clears_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_code_checked) |-> (rsp_digits_entered == 3'd0))
      else $error("entry not cleared after enter");

   a_notice_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_notice == pclk_pkg::NOTE_NONE || rsp_notice == pclk_pkg::NOTE_OK ||
                     rsp_notice == pclk_pkg::NOTE_WRONG))
      else $error("reserved notice code on rsp");
`endif

endmodule
